// File: rtl/pbdt_pkg.sv
// pbdt_pkg: shared types and fixed widths for the drop-tail packet buffer.
// Used by pbdt_cell and packet_buffer_drop_tail; depends on nothing.
`default_nettype none
package pbdt_pkg;

   localparam int PORT_TIME_W = 32;         // width of the time fields on the ports
   localparam int CSR_W       = 7;          // width of buffer_size
   localparam logic [CSR_W-1:0] CSR_BUFFER_SIZE_RESET = 7'd64;

   // Per-cycle command broadcast from the controller to every cell.
   typedef struct packed {
      logic pop;    // shift every entry one cell toward the head
      logic push;   // write the new finish time into the first free cell
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/pbdt_cell.sv
// pbdt_cell: one slot of the shifting finish-time queue.
// Takes its neighbor's entry on a pop, loads the new entry when it is the first free slot.
// Depends on pbdt_pkg.
`default_nettype none
module pbdt_cell #(
   parameter int TIME_WIDTH = 32,
   parameter int CNT_W      = 7,
   parameter int INDEX      = 0
) (
   input  wire                           clock,
   input  pbdt_pkg::cell_ctrl_type       ctrl,
   input  wire  [CNT_W-1:0]              occupancy,
   input  wire  [TIME_WIDTH-1:0]         push_time,
   input  wire  [TIME_WIDTH-1:0]         next_time,
   output logic [TIME_WIDTH-1:0]         cell_time
);
   import pbdt_pkg::*;

   logic [TIME_WIDTH-1:0] time_ff;
   logic [TIME_WIDTH-1:0] time_in;
   logic                  is_tail;

   // this cell is the first free slot when the fill count points at it
   assign is_tail = (occupancy == CNT_W'(INDEX));

   always_comb begin
      time_in = time_ff;
      if (ctrl.push && is_tail) begin
         time_in = push_time;
      end else if (ctrl.pop) begin
         time_in = next_time;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
   end

   assign cell_time = time_ff;

endmodule
`default_nettype wire

// File: rtl/packet_buffer_drop_tail.sv
// Drop-tail packet buffer: one result item per request item.
// Flow: an accepted item stays in ST_RETIRE until no head entry has retired, then passes ST_FINISH
// (skipped when it is dropped) and ST_RESULT, which waits until the output register is free;
// the retire loop pops one cell per cycle, and a new item enters once the last result is loaded.
// Reset: synchronous; queue empty, buffer_size = 64, no result pending.
// Depends on pbdt_pkg and pbdt_cell.
`default_nettype none
module packet_buffer_drop_tail #(
   parameter int DEPTH      = 64,
   parameter int TIME_WIDTH = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [pbdt_pkg::PORT_TIME_W-1:0]   req_arrival_time,
   input  wire  [pbdt_pkg::PORT_TIME_W-1:0]   req_process_time,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_dropped,
   output logic [pbdt_pkg::PORT_TIME_W-1:0]   rsp_begin_time,
   // configuration
   input  wire                                csr_wr_en,
   input  wire  [pbdt_pkg::CSR_W-1:0]         csr_wr_data
);
   import pbdt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RETIRE = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CSR_W-1:0]        buffer_size_ff, buffer_size_in;
   logic [CNT_W-1:0]        occupancy_ff, occupancy_in;
   logic [TIME_WIDTH-1:0]   arrival_ff, arrival_in;
   logic [TIME_WIDTH-1:0]   service_ff, service_in;
   logic [TIME_WIDTH-1:0]   start_ff, start_in;
   logic                    drop_ff, drop_in;
   logic [TIME_WIDTH-1:0]   last_finish_ff, last_finish_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_dropped_ff, rsp_dropped_in;
   logic [PORT_TIME_W-1:0]  rsp_start_ff, rsp_start_in;

   cell_ctrl_type           ctrl;
   logic [TIME_WIDTH-1:0]   cell_time [DEPTH];
   logic [TIME_WIDTH-1:0]   finish_time;
   logic [TIME_WIDTH:0]     finish_sum;
   logic [CMP_W-1:0]        capacity;
   logic [CMP_W-1:0]        buf_ext;
   logic                    retire;
   logic                    full;
   logic                    out_free;

   // ---------------- queue of finish times ----------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [TIME_WIDTH-1:0] next_time;
      if (i == DEPTH - 1) begin : g_last
         assign next_time = '0;
      end else begin : g_mid
         assign next_time = cell_time[i+1];
      end
      pbdt_cell #(
         .TIME_WIDTH (TIME_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupancy  (occupancy_ff),
         .push_time  (finish_time),
         .next_time  (next_time),
         .cell_time  (cell_time[i])
      );
   end

   // ---------------- capacity: clamp buffer_size to [1, DEPTH] ----------------
   always_comb begin
      buf_ext = CMP_W'(buffer_size_ff);
      if (buf_ext == '0) begin
         capacity = CMP_W'(1);
      end else if (buf_ext > CMP_W'(DEPTH)) begin
         capacity = CMP_W'(DEPTH);
      end else begin
         capacity = buf_ext;
      end
   end

   assign retire   = (occupancy_ff != '0) && (cell_time[0] <= arrival_ff);
   assign full     = (CMP_W'(occupancy_ff) >= capacity);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // saturating finish time
   assign finish_sum  = {1'b0, start_ff} + {1'b0, service_ff};
   assign finish_time = finish_sum[TIME_WIDTH] ? '1 : finish_sum[TIME_WIDTH-1:0];

   assign req_ready = (state_ff == ST_IDLE);

   // ---------------- controller ----------------
   always_comb begin
      state_in       = state_ff;
      buffer_size_in = csr_wr_en ? csr_wr_data : buffer_size_ff;
      occupancy_in   = occupancy_ff;
      arrival_in     = arrival_ff;
      service_in     = service_ff;
      start_in       = start_ff;
      drop_in        = drop_ff;
      last_finish_in = last_finish_ff;
      ctrl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               arrival_in = TIME_WIDTH'(req_arrival_time);
               service_in = TIME_WIDTH'(req_process_time);
               state_in   = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if (retire) begin
               // drop the head entry, it finished by the arrival
               ctrl.pop     = 1'b1;
               occupancy_in = occupancy_ff - CNT_W'(1);
            end else if (full) begin
               drop_in  = 1'b1;
               start_in = '0;
               state_in = ST_RESULT;
            end else begin
               drop_in  = 1'b0;
               start_in = ((occupancy_ff != '0) && (last_finish_ff > arrival_ff))
                          ? last_finish_ff : arrival_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctrl.push      = 1'b1;
            occupancy_in   = occupancy_ff + CNT_W'(1);
            last_finish_in = finish_time;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_start_in   = rsp_start_ff;
      if ((state_ff == ST_RESULT) && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_dropped_in = drop_ff;
         rsp_start_in   = PORT_TIME_W'(start_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         buffer_size_ff <= CSR_BUFFER_SIZE_RESET;
         occupancy_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         buffer_size_ff <= buffer_size_in;
         occupancy_ff   <= occupancy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff     <= arrival_in;
      service_ff     <= service_in;
      start_ff       <= start_in;
      drop_ff        <= drop_in;
      last_finish_ff <= last_finish_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_start_ff   <= rsp_start_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_begin_time = rsp_start_ff;

   // ---------------- assertions ----------------
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occupancy_ff) <= CMP_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> (occupancy_ff != '0))
      else $error("pop from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> (CMP_W'(occupancy_ff) < capacity))
      else $error("push into full buffer");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dropped_ff) |-> (rsp_start_ff == '0))
      else $error("dropped item with nonzero start time");

   a_push_sequence: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> (state_ff == ST_RESULT))
      else $error("push not followed by result");

endmodule
`default_nettype wire
